@@ hw/rtl/sgj_pkg.sv @@
package sgj_pkg;

   localparam int JOINT_COUNT = 4;
   localparam int SINE_TABLE_DEPTH_DEF = 256;
   localparam int PIPE_STAGES = 5;

   localparam int AMP_W = 15;
   localparam int PHASE_W = 32;
   localparam int ANGLE_W = 16;
   localparam int OFF_W = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [AMP_W-1:0] LATERAL_AMP_RESET = 15'd8192;
   localparam logic [AMP_W-1:0] VERTICAL_AMP_RESET = 15'd2867;
   localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd4294967;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int TAYLOR_TERMS = 12;
   localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   typedef enum logic [2:0] {
      GAIT_FORWARD    = 3'd0,
      GAIT_TURN_LEFT  = 3'd1,
      GAIT_TURN_RIGHT = 3'd2,
      GAIT_MOVE_LEFT  = 3'd3,
      GAIT_MOVE_RIGHT = 3'd4
   } gait_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LATERAL_AMP  = 2'd0,
      CSR_VERTICAL_AMP = 2'd1,
      CSR_PHASE_STEP   = 2'd2
   } csr_index_type;

   // joint offsets in eighths of a turn, joint 0 in the low slice
   typedef struct packed {
      logic [JOINT_COUNT-1:0][OFF_W-1:0] lat;
      logic [JOINT_COUNT-1:0][OFF_W-1:0] vert;
   } gait_offsets_type;

   function automatic gait_offsets_type gait_offsets(input logic [2:0] mode);
      gait_offsets_type o;
      o.lat  = {3'd4, 3'd4, 3'd2, 3'd2};
      o.vert = {3'd2, 3'd2, 3'd2, 3'd2};
      unique case (gait_mode_type'(mode))
         GAIT_TURN_LEFT: begin
            o.lat  = {3'd4, 3'd2, 3'd4, 3'd2};
            o.vert = {3'd4, 3'd2, 3'd4, 3'd2};
         end
         GAIT_TURN_RIGHT: begin
            o.lat  = {3'd1, 3'd4, 3'd1, 3'd4};
         end
         GAIT_MOVE_RIGHT: begin
            o.lat  = {3'd2, 3'd2, 3'd2, 3'd2};
            o.vert = {3'd4, 3'd1, 3'd4, 3'd1};
         end
         default: begin
            o.lat  = {3'd4, 3'd4, 3'd2, 3'd2};
         end
      endcase
      return o;
   endfunction

endpackage

@@ hw/rtl/sgj_req_if.sv @@
interface sgj_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] time_ms;
   logic [2:0]  gait_mode;

   modport source (output valid, output time_ms, output gait_mode, input ready);
   modport sink (input valid, input time_ms, input gait_mode, output ready);
endinterface

@@ hw/rtl/sgj_rsp_if.sv @@
interface sgj_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] lateral_angle_0;
   logic signed [15:0] lateral_angle_1;
   logic signed [15:0] lateral_angle_2;
   logic signed [15:0] lateral_angle_3;
   logic signed [15:0] vertical_angle_0;
   logic signed [15:0] vertical_angle_1;
   logic signed [15:0] vertical_angle_2;
   logic signed [15:0] vertical_angle_3;

   modport source (
      output valid,
      output lateral_angle_0, output lateral_angle_1,
      output lateral_angle_2, output lateral_angle_3,
      output vertical_angle_0, output vertical_angle_1,
      output vertical_angle_2, output vertical_angle_3,
      input ready
   );
   modport sink (
      input valid,
      input lateral_angle_0, input lateral_angle_1,
      input lateral_angle_2, input lateral_angle_3,
      input vertical_angle_0, input vertical_angle_1,
      input vertical_angle_2, input vertical_angle_3,
      output ready
   );
endinterface

@@ hw/rtl/snake_gait_joint_angle_generator.sv @@
// Serpenoid gait generator: each item (time_ms, gait_mode) yields one item of four lateral
// and four vertical joint angles, amplitude times sine of time_ms * phase_step plus a
// per-mode joint offset, in Q14 radians. Five-stage pipeline: phase multiply, table address,
// sine table read, amplitude multiply, round and saturate. One item per cycle sustained while no
// result waits at the output; a stalled result holds every stage, so req_ch.ready
// is low exactly while a result waits. Each of the eight joint lanes has its own copy of
// the SINE_TABLE_DEPTH+1 entry quarter-wave table. Write csr registers only while idle.
module snake_gait_joint_angle_generator
   import sgj_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   sgj_req_if.sink                req_ch,
   sgj_rsp_if.source              rsp_ch,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // configuration registers
   logic [AMP_W-1:0]   lat_amp_ff, lat_amp_in;
   logic [AMP_W-1:0]   vert_amp_ff, vert_amp_in;
   logic [PHASE_W-1:0] phase_step_ff, phase_step_in;

   always_comb begin
      lat_amp_in    = lat_amp_ff;
      vert_amp_in   = vert_amp_ff;
      phase_step_in = phase_step_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LATERAL_AMP:  lat_amp_in    = csr_write_data[AMP_W-1:0];
            CSR_VERTICAL_AMP: vert_amp_in   = csr_write_data[AMP_W-1:0];
            CSR_PHASE_STEP:   phase_step_in = csr_write_data[PHASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_amp_ff    <= LATERAL_AMP_RESET;
         vert_amp_ff   <= VERTICAL_AMP_RESET;
         phase_step_ff <= PHASE_STEP_RESET;
      end else begin
         lat_amp_ff    <= lat_amp_in;
         vert_amp_ff   <= vert_amp_in;
         phase_step_ff <= phase_step_in;
      end
   end

   // pipeline control
   logic                   en;
   logic                   accept;
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;

   assign en     = !valid_ff[PIPE_STAGES-1] || rsp_ch.ready;
   assign accept = req_ch.valid && en;

   always_comb begin
      valid_in = en ? {valid_ff[PIPE_STAGES-2:0], accept} : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else
         valid_ff <= valid_in;
   end

   assign req_ch.ready = en;
   assign rsp_ch.valid = valid_ff[PIPE_STAGES-1];

   // datapath
   logic [PHASE_W-1:0]        base;
   gait_offsets_type          offsets;
   logic signed [ANGLE_W-1:0] lat_angle [JOINT_COUNT];
   logic signed [ANGLE_W-1:0] vert_angle [JOINT_COUNT];

   sgj_phase u_phase (
      .clock      (clock),
      .en         (en),
      .time_ms    (req_ch.time_ms),
      .gait_mode  (req_ch.gait_mode),
      .phase_step (phase_step_ff),
      .base       (base),
      .offsets    (offsets)
   );

   for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_joint
      sgj_joint_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_lat (
         .clock     (clock),
         .en        (en),
         .base      (base),
         .offset    (offsets.lat[j]),
         .amplitude (lat_amp_ff),
         .angle     (lat_angle[j])
      );
      sgj_joint_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_vert (
         .clock     (clock),
         .en        (en),
         .base      (base),
         .offset    (offsets.vert[j]),
         .amplitude (vert_amp_ff),
         .angle     (vert_angle[j])
      );
   end

   assign rsp_ch.lateral_angle_0  = lat_angle[0];
   assign rsp_ch.lateral_angle_1  = lat_angle[1];
   assign rsp_ch.lateral_angle_2  = lat_angle[2];
   assign rsp_ch.lateral_angle_3  = lat_angle[3];
   assign rsp_ch.vertical_angle_0 = vert_angle[0];
   assign rsp_ch.vertical_angle_1 = vert_angle[1];
   assign rsp_ch.vertical_angle_2 = vert_angle[2];
   assign rsp_ch.vertical_angle_3 = vert_angle[3];

endmodule

@@ hw/rtl/sgj_phase.sv @@
module sgj_phase
   import sgj_pkg::*;
(
   input  logic                   clock,
   input  logic                   en,
   input  logic [31:0]            time_ms,
   input  logic [2:0]             gait_mode,
   input  logic [PHASE_W-1:0]     phase_step,
   output logic [PHASE_W-1:0]     base,
   output gait_offsets_type       offsets
);

   logic [PHASE_W-1:0] base_ff, base_in;
   gait_offsets_type   offsets_ff, offsets_in;

   // phase wraps modulo one turn, only the low word is kept
   always_comb begin
      base_in    = PHASE_W'(time_ms * phase_step);
      offsets_in = gait_offsets(gait_mode);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff    <= base_in;
         offsets_ff <= offsets_in;
      end
   end

   assign base    = base_ff;
   assign offsets = offsets_ff;

endmodule

@@ hw/rtl/sgj_joint_lane.sv @@
module sgj_joint_lane
   import sgj_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
)
(
   input  logic                      clock,
   input  logic                      en,
   input  logic [PHASE_W-1:0]        base,
   input  logic [OFF_W-1:0]          offset,
   input  logic [AMP_W-1:0]          amplitude,
   output logic signed [ANGLE_W-1:0] angle
);

   localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PW = 30 + AW;
   localparam int SW = 15;

   typedef logic [SW-1:0] rom_type [SINE_TABLE_DEPTH + 1];

   function automatic logic [SW-1:0] sine_entry(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
         if (n % 2 == 1)
            sum = sum - $signed(term);
         else
            sum = sum + $signed(term);
      end
      if (sum < 0)
         sum = 0;
      v = (sum + 64'sd32768) >>> 16;
      if (v > 64'sd16384)
         v = 64'sd16384;
      return SW'(v);
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
         r[k] = sine_entry(k);
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // stage 2: joint phase, quadrant and table address
   logic [PHASE_W-1:0] phase;
   logic [PW-1:0]      scaled;
   logic [AW-1:0]      idx;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               neg2_ff, neg2_in;

   always_comb begin
      phase   = base + {offset, 29'd0};
      scaled  = PW'(phase[29:0]) * PW'(SINE_TABLE_DEPTH);
      idx     = scaled[PW-1:30];
      addr_in = phase[30] ? (AW'(SINE_TABLE_DEPTH) - idx) : idx;
      neg2_in = phase[31];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         addr_ff <= addr_in;
         neg2_ff <= neg2_in;
      end
   end

   // stage 3: table read
   logic [SW-1:0] sine_ff;
   logic          neg3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff <= SINE_ROM[addr_ff];
         neg3_ff <= neg2_ff;
      end
   end

   // stage 4: signed product, Q28
   logic signed [15:0] sine_s;
   logic signed [15:0] amp_s;
   logic signed [31:0] prod_full;
   logic signed [30:0] prod_ff, prod_in;

   always_comb begin
      sine_s    = neg3_ff ? -$signed({1'b0, sine_ff}) : $signed({1'b0, sine_ff});
      amp_s     = $signed({1'b0, amplitude});
      prod_full = amp_s * sine_s;
      prod_in   = 31'(prod_full);
   end

   always_ff @(posedge clock) begin
      if (en)
         prod_ff <= prod_in;
   end

   // stage 5: round to q14 and saturate
   logic signed [31:0]        rnd;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;

   always_comb begin
      rnd = (32'(prod_ff) + 32'sd8192) >>> 14;
      if (rnd > 32'sd32767)
         angle_in = 16'sh7fff;
      else if (rnd < -32'sd32768)
         angle_in = 16'sh8000;
      else
         angle_in = 16'(rnd);
   end

   always_ff @(posedge clock) begin
      if (en)
         angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

@@ hw/rtl/sgj_checker.sv @@
module sgj_checker
   import sgj_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [ANGLE_W-1:0] lat_0,
   input logic signed [ANGLE_W-1:0] lat_1,
   input logic signed [ANGLE_W-1:0] lat_2,
   input logic signed [ANGLE_W-1:0] lat_3,
   input logic signed [ANGLE_W-1:0] vert_0,
   input logic signed [ANGLE_W-1:0] vert_1,
   input logic signed [ANGLE_W-1:0] vert_2,
   input logic signed [ANGLE_W-1:0] vert_3
);

   // no item comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // the input side stalls exactly while a result waits
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   // an accepted item reaches the output when rsp_ready stays high while it moves through the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      |=> rsp_valid)
      else $error("item lost in the pipeline");

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(lat_0) && $stable(lat_1)
      && $stable(lat_2) && $stable(lat_3) && $stable(vert_0) && $stable(vert_1)
      && $stable(vert_2) && $stable(vert_3))
      else $error("stalled item changed");

endmodule

bind snake_gait_joint_angle_generator sgj_checker u_sgj_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .lat_0     (rsp_ch.lateral_angle_0),
   .lat_1     (rsp_ch.lateral_angle_1),
   .lat_2     (rsp_ch.lateral_angle_2),
   .lat_3     (rsp_ch.lateral_angle_3),
   .vert_0    (rsp_ch.vertical_angle_0),
   .vert_1    (rsp_ch.vertical_angle_1),
   .vert_2    (rsp_ch.vertical_angle_2),
   .vert_3    (rsp_ch.vertical_angle_3)
);
